// ===== hw/rtl/b32enc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b32enc_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
    localparam logic [6:0] ALPHA_BASE = 7'h41;  // 'A'
    localparam logic [6:0] DIGIT_BASE = 7'h32;  // '2'
    localparam logic [4:0] DIGIT_FIRST = 5'd26;

    typedef logic [4:0] sym_t;

    // One accepted byte's worth of output work: up to three symbols in
    // emission order, followed by a run of pad characters.
    typedef struct packed {
        sym_t [2:0] sym;
        logic [1:0] nsym;
        logic [2:0] npad;
        logic       fin;
    } job_t;

    function automatic logic [6:0] sym_to_ascii(input sym_t s);
        logic [6:0] r;
        if (s < DIGIT_FIRST)
            r = ALPHA_BASE + {2'b00, s};
        else
            r = DIGIT_BASE + {2'b00, s - DIGIT_FIRST};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b32enc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b32enc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pad_en,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic               final_byte,
    input  wire logic               q_full,
    output logic                    q_push,
    output b32enc_pkg::job_t        q_data
);
    import b32enc_pkg::*;

    logic [3:0] acc_reg, acc_next;
    logic [2:0] bc_reg, bc_next;
    logic [2:0] cc_reg, cc_next;

    logic [2:0]  bits_in;
    logic [11:0] acc12;
    logic [3:0]  total;
    logic        two;
    sym_t        sym0, sym1, flush;
    logic [2:0]  rem;
    logic [3:0]  rem_mask, rem_val;
    logic        has_flush;
    logic [1:0]  nchar;
    logic [2:0]  cc_after, pad_raw;
    logic [3:0]  pad_cap;
    logic [2:0]  npad;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        bits_in   = (bc_reg > 3'd4) ? 3'd4 : bc_reg;
        acc12     = {acc_reg, data_byte};
        total     = {1'b0, bits_in} + 4'd8;
        two       = (total >= 4'd10);
        sym0      = 5'(acc12 >> (total - 4'd5));
        sym1      = 5'(acc12 >> (total - 4'd10));
        rem       = 3'(total - (two ? 4'd10 : 4'd5));
        rem_mask  = 4'((5'd1 << rem) - 5'd1);
        rem_val   = acc12[3:0] & rem_mask;
        // Leftover bits go out left-justified with zero fill.
        flush     = 5'({1'b0, rem_val} << (3'd5 - rem));
        has_flush = final_byte && (rem != 3'd0);
        nchar     = (two ? 2'd2 : 2'd1) + {1'b0, has_flush};
        cc_after  = cc_reg + {1'b0, nchar};
        pad_raw   = (pad_en && final_byte) ? 3'(3'd0 - cc_after) : 3'd0;
        pad_cap   = 4'd8 - {2'b00, nchar};
        npad      = ({1'b0, pad_raw} > pad_cap) ? 3'(pad_cap) : pad_raw;

        q_data.sym[0] = sym0;
        q_data.sym[1] = two ? sym1 : flush;
        q_data.sym[2] = flush;
        q_data.nsym   = nchar;
        q_data.npad   = npad;
        q_data.fin    = final_byte;

        if (final_byte)
        begin
            acc_next = 4'd0;
            bc_next  = 3'd0;
            cc_next  = 3'd0;
        end
        else
        begin
            acc_next = rem_val;
            bc_next  = rem;
            cc_next  = cc_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 4'd0;
            bc_reg  <= 3'd0;
            cc_reg  <= 3'd0;
        end
        else if (q_push)
        begin
            acc_reg <= acc_next;
            bc_reg  <= bc_next;
            cc_reg  <= cc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b32enc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b32enc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire b32enc_pkg::job_t   push_data,
    output logic                    full,
    input  wire logic               pop,
    output b32enc_pkg::job_t        head,
    output logic                    empty
);
    import b32enc_pkg::*;

    job_t mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("job queue count did not advance on write");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/b32enc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b32enc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire b32enc_pkg::job_t   head,
    input  wire logic               q_empty,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [6:0]              out_char,
    output logic                    last_char
);
    import b32enc_pkg::*;

    logic [2:0] step_reg;
    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       last_char_reg;

    logic [3:0] total;
    logic       last_step;
    logic       load;
    sym_t       sel;
    logic [6:0] ch;

    always_comb
    begin
        total     = {2'b00, head.nsym} + {1'b0, head.npad};
        last_step = ({1'b0, step_reg} == (total - 4'd1));
        load      = !q_empty && (!out_valid_reg || out_ready);
        q_pop     = load && last_step;
        unique case (step_reg[1:0])
            2'd0:    sel = head.sym[0];
            2'd1:    sel = head.sym[1];
            default: sel = head.sym[2];
        endcase
        ch = ({1'b0, step_reg} < {2'b00, head.nsym}) ? sym_to_ascii(sel) : PAD_CHAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= last_step ? 3'd0 : step_reg + 3'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg  <= ch;
            last_char_reg <= head.fin && last_step;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

`ifndef SYNTH
    a_step_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> {1'b0, step_reg} < total)
        else $error("character step ran past the end of its job");
    a_step_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> step_reg == 3'd0)
        else $error("step counter not rewound after a job completed");
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> step_reg == 3'd0)
        else $error("step counter left mid-job with no job queued");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/base32_encoder_padded.sv =====
// Streaming base32 encoder (A-Z, 2-7 alphabet) with optional '=' padding.
// Input channel: in_valid/in_ready carry one message byte per item in
// data_byte, with final_byte set on the last byte of a message.
// Output channel: out_valid/out_ready carry one ASCII character per item in
// out_char; last_char is set on the final character of a message.
// cfg_wr_en writes cfg_wr_data into the pad enable bit; write
// it only between messages. After reset padding is on.
// Each byte yields one or two characters, plus on the final byte a flush
// character if bits are left over and up to six pad characters. The output
// side moves one character per cycle while out_ready is high, through a
// single character register. A byte's characters pass through the job
// queue and then that output register.
// The byte classifier feeds a two-entry job queue, so in_ready stays high
// while the queue has room even when the receiver stalls; a stalled
// character holds in the output register until taken.
// Reset clears the encoder state, the queue and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module base32_encoder_padded (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [6:0]       out_char,
    output logic             last_char
);
    import b32enc_pkg::*;

    logic pad_en_reg;
    logic q_full, q_empty, q_push, q_pop;
    job_t q_in, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_en_reg <= 1'b1;
        else if (cfg_wr_en)
            pad_en_reg <= cfg_wr_data;
    end

    b32enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pad_en     (pad_en_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    b32enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    b32enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last_char  (last_char)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_DIGIT_2 = 7'h32;
    localparam logic [6:0] CH_PAD     = 7'h3D;
    localparam int         MAX_CHARS  = 8;
    localparam int         QUIET_LIMIT = 5000;
    localparam int         HOLD_SPAN  = 250;
    localparam int         RANDOM_ITEMS = 410;
    localparam int         REPORT_MAX = 10;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [6:0] out_char;
    logic       last_char;

    // Encoder state as predicted from the accepted bytes.
    logic [11:0] acc_bits;
    logic [3:0]  acc_count;
    logic [2:0]  chars_mod8;
    logic        pad_on;

    char_item_t  expected_chars[$];
    char_item_t  staged_chars[MAX_CHARS];
    int          staged_n;
    char_item_t  want;

    int fail_count = 0;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int hold_left = 0;
    int rx_cycle = 0;
    int rx_mode = 0;
    bit hold_trigger = 1'b0;

    base32_encoder_padded u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .final_byte  (final_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_char   (last_char)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [6:0] symbol_char(input logic [4:0] v);
        if (v < 5'd26)
            return CH_UPPER_A + {2'b00, v};
        return CH_DIGIT_2 + {2'b00, v - 5'd26};
    endfunction

    function automatic void stage_char(input logic [6:0] ch);
        if (staged_n < MAX_CHARS)
        begin
            staged_chars[staged_n] = '{ch: ch, last: 1'b0};
            staged_n++;
            chars_mod8 = chars_mod8 + 3'd1;
        end
    endfunction

    // Works out the characters that one accepted byte produces.
    function automatic void encode_byte(input logic [7:0] data, input logic fin);
        logic [19:0] bits;
        logic [19:0] group;
        int          nbits;
        staged_n = 0;
        bits = {8'd0, acc_bits & ((12'd1 << acc_count) - 12'd1)};
        bits = (bits << 8) | {12'd0, data};
        nbits = int'(acc_count) + 8;
        while (nbits >= 5)
        begin
            group = bits >> (nbits - 5);
            stage_char(symbol_char(group[4:0]));
            nbits -= 5;
        end
        bits &= (20'd1 << nbits) - 20'd1;
        if (fin)
        begin
            if (nbits > 0)
            begin
                group = bits << (5 - nbits);
                stage_char(symbol_char(group[4:0]));
            end
            if (pad_on)
                while (chars_mod8 != 3'd0 && staged_n < MAX_CHARS)
                    stage_char(CH_PAD);
            if (staged_n > 0)
                staged_chars[staged_n - 1].last = 1'b1;
            acc_bits = '0;
            acc_count = '0;
            chars_mod8 = '0;
        end
        else
        begin
            acc_bits = bits[11:0];
            acc_count = 4'(nbits);
        end
        for (int i = 0; i < staged_n; i++)
            expected_chars.push_back(staged_chars[i]);
    endfunction

    // Offers one byte and waits until the block takes it. Between bursts the
    // sender drops valid for a random gap.
    task automatic send_byte(input logic [7:0] data, input logic fin, input bit allow_gap);
        int gap;
        @(negedge clk);
        if (allow_gap && burst_left == 0)
        begin
            gap = $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        data_byte <= data;
        final_byte <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        encode_byte(data, fin);
        bytes_sent++;
    endtask

    task automatic send_message(input int len, input bit allow_gap);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1, allow_gap);
    endtask

    // Configuration changes only once every pending character has come out.
    task automatic set_padding(input logic value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_chars.size() > 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        pad_on = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_padded_lengths();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hAA, 1'b0, 1'b1);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h80, 1'b0, 1'b1);
        send_byte(8'h7F, 1'b0, 1'b1);
        send_byte(8'hFE, 1'b1, 1'b1);
        // Five bytes fill exactly eight characters, so nothing is flushed or padded.
        for (int i = 0; i < 5; i++)
            send_byte(8'hFF, i == 4, 1'b1);
    endtask

    task automatic test_unpadded();
        set_padding(1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b1, 1'b1);
    endtask

    // Only the setting seen with the last byte decides the padding.
    task automatic test_pad_change_inside_message();
        send_byte(8'h66, 1'b0, 1'b1);
        set_padding(1'b1);
        send_byte(8'h6F, 1'b1, 1'b1);
        send_byte(8'h12, 1'b0, 1'b1);
        set_padding(1'b0);
        send_byte(8'h34, 1'b1, 1'b1);
    endtask

    task automatic test_random_messages();
        int msg_count;
        int len;
        int pick;
        msg_count = 0;
        while (bytes_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
                len = $urandom_range(1, 10);
            else if (pick < 19)
                len = $urandom_range(11, 30);
            else
                len = $urandom_range(31, 60);
            send_message(len, 1'b1);
            msg_count++;
            if (msg_count % 5 == 0)
                set_padding(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_receiver_hold();
        set_padding(1'b1);
        @(posedge clk);
        hold_trigger = 1'b1;
        send_message(40, 1'b0);
    endtask

    // Receiver: the stall style is redrawn at random from time to time, with
    // one long hold requested by the backpressure test.
    always @(negedge clk)
    begin
        if (hold_trigger)
        begin
            hold_trigger = 1'b0;
            hold_left = HOLD_SPAN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 48 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_cycle % 5 < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected char: got char=%h last=%b", out_char, last_char);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.ch || last_char !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("char mismatch: expected char=%h last=%b, got char=%h last=%b",
                                 want.ch, want.last, out_char, last_char);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("base32_encoder_padded verification failed");
            $finish;
        end
    end

    initial
    begin
        acc_bits = '0;
        acc_count = '0;
        chars_mod8 = '0;
        pad_on = 1'b1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_padded_lengths();
        test_unpadded();
        test_pad_change_inside_message();
        test_random_messages();
        test_receiver_hold();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_chars.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_chars.size() == 0)
            $display("base32_encoder_padded verification clean");
        else
            $display("base32_encoder_padded verification failed");
        $finish;
    end

endmodule
